// File: design/pvm_pkg.sv
// Package for the priority velocity multiplexer.
// Holds beat types, operation codes, controller/datapath bundles and constants.
// No dependencies.
package pvm_pkg;

    // Operation codes of an input beat. Code 3 has no meaning and changes nothing.
    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_VELOCITY = 2'd1,
        OP_TICK     = 2'd2
    } t_op;

    localparam logic [7:0]  LOCK_FREE      = 8'hFF;
    localparam logic [15:0] HOLD_MAX       = 16'd2000;
    localparam logic [14:0] TICKS_PER_HOLD = 15'd10;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  source_id;
        logic [7:0]  source_priority;
        logic [15:0] hold_time;
        logic [31:0] linear_speed;
        logic [31:0] angular_speed;
    } t_in_beat;

    typedef struct packed {
        logic        register_ok;
        logic [3:0]  assigned_index;
        logic        command_accepted;
        logic [31:0] held_linear;
        logic [31:0] held_angular;
        logic        lock_expired;
        logic [7:0]  lock_priority;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

// File: design/pvm_if.sv
// Valid/ready channel interfaces for the priority velocity multiplexer.
// pvm_in_if carries input beats, pvm_out_if carries result beats. No dependencies.
interface pvm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [7:0]  source_id;
    logic [7:0]  source_priority;
    logic [15:0] hold_time;
    logic [31:0] linear_speed;
    logic [31:0] angular_speed;

    modport source (
        output valid, operation, source_id, source_priority, hold_time,
               linear_speed, angular_speed,
        input  ready
    );
    modport sink (
        input  valid, operation, source_id, source_priority, hold_time,
               linear_speed, angular_speed,
        output ready
    );
endinterface

interface pvm_out_if;
    logic        valid;
    logic        ready;
    logic        register_ok;
    logic [3:0]  assigned_index;
    logic        command_accepted;
    logic [31:0] held_linear;
    logic [31:0] held_angular;
    logic        lock_expired;
    logic [7:0]  lock_priority;

    modport source (
        output valid, register_ok, assigned_index, command_accepted, held_linear,
               held_angular, lock_expired, lock_priority,
        input  ready
    );
    modport sink (
        input  valid, register_ok, assigned_index, command_accepted, held_linear,
               held_angular, lock_expired, lock_priority,
        output ready
    );
endinterface

// File: design/priority_velocity_mux.sv
// Priority velocity multiplexer, top level. Depends on pvm_pkg, pvm_if, pvm_ctrl, pvm_dp.
// A result beat is registered: the accepted beat and its table read are captured at
// accept, then the execute state loads the result register once it is free. A new
// input beat is taken only after the execute state has loaded the last one's result.
// Reset (i_rst_n, synchronous, active low): no sources, lock free at 255, timer
// stopped, held velocity pair zero, no result pending; the tables need no clearing.
module priority_velocity_mux #(
    parameter int MAX_SOURCES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pvm_in_if.sink      i_cmd,
    pvm_out_if.source   o_res
);

    // Controller and datapath talk only through these two bundles.
    pvm_pkg::t_cmd      cmd;
    pvm_pkg::t_status   status;
    pvm_pkg::t_in_beat  in_beat;
    pvm_pkg::t_out_beat out_beat;
    logic               out_valid;

    // Gather the input channel's payload into one beat.
    always_comb begin
        in_beat.operation       = i_cmd.operation;
        in_beat.source_id       = i_cmd.source_id;
        in_beat.source_priority = i_cmd.source_priority;
        in_beat.hold_time       = i_cmd.hold_time;
        in_beat.linear_speed    = i_cmd.linear_speed;
        in_beat.angular_speed   = i_cmd.angular_speed;
    end

    // The sequencer accepts a beat only when idle; it then holds in its
    // execute state until the result register is free to take the new beat.
    pvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath owns the source tables, the lock, the hold timer and the
    // result register that decouples the output side from the input side.
    pvm_dp #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_beat      (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (o_res.ready),
        .o_out_beat  (out_beat)
    );

    // Spread the result beat onto the output channel.
    always_comb begin
        o_res.valid            = out_valid;
        o_res.register_ok      = out_beat.register_ok;
        o_res.assigned_index   = out_beat.assigned_index;
        o_res.command_accepted = out_beat.command_accepted;
        o_res.held_linear      = out_beat.held_linear;
        o_res.held_angular     = out_beat.held_angular;
        o_res.lock_expired     = out_beat.lock_expired;
        o_res.lock_priority    = out_beat.lock_priority;
    end

endmodule

// File: design/pvm_ctrl.sv
// Controller of the priority velocity multiplexer: a two-state sequencer.
// Depends on pvm_pkg for the command and status bundles.
module pvm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pvm_pkg::t_status  i_status,
    output pvm_pkg::t_cmd     o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_ready;

    always_comb begin
        o_cmd.capture = i_in_valid && r_ready;
        o_cmd.execute = (r_state == S_EXEC) && i_status.out_free;
    end

    assign o_in_ready = r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_ready <= 1'b1;
                    if (i_in_valid && r_ready) begin
                        r_state <= S_EXEC;
                        r_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    // Stay here until the result register can take the beat.
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_ready <= 1'b0;
                end
            endcase
        end
    end

endmodule

// File: design/pvm_dp.sv
// Datapath of the priority velocity multiplexer: source tables, lock, timer,
// held velocity pair and the result register. Depends on pvm_pkg.
module pvm_dp #(
    parameter int MAX_SOURCES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pvm_pkg::t_cmd       i_cmd,
    output pvm_pkg::t_status    o_status,
    input  pvm_pkg::t_in_beat   i_beat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pvm_pkg::t_out_beat  o_out_beat
);

    localparam int CW   = $clog2(MAX_SOURCES + 1);
    localparam int IW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int CMPW = (CW > 8) ? CW : 8;

    // Source tables. Only entries below the fill count are ever used.
    logic [7:0]  mem_prio [MAX_SOURCES];
    logic [15:0] mem_hold [MAX_SOURCES];

    // Captured input beat and registered table read.
    logic [1:0]  r_op;
    logic [7:0]  r_id;
    logic [7:0]  r_prio_in;
    logic [15:0] r_hold_in;
    logic [31:0] r_lin_in;
    logic [31:0] r_ang_in;
    logic [7:0]  r_rd_prio;
    logic [15:0] r_rd_hold;

    // Architectural state.
    logic [CW-1:0] r_count,    n_count;
    logic [7:0]    r_lock,     n_lock;
    logic [14:0]   r_tcnt,     n_tcnt;
    logic [14:0]   r_tlim,     n_tlim;
    logic          r_trun,     n_trun;
    logic [31:0]   r_lin_hold, n_lin_hold;
    logic [31:0]   r_ang_hold, n_ang_hold;

    logic                r_out_valid;
    pvm_pkg::t_out_beat  r_out, n_out;

    logic          reg_ok;
    logic          accepted;
    logic          expired;
    logic          id_known;
    logic          hold_arms;
    logic [14:0]   tcnt_inc;

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_beat        = r_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op      <= i_beat.operation;
            r_id      <= i_beat.source_id;
            r_prio_in <= i_beat.source_priority;
            r_hold_in <= i_beat.hold_time;
            r_lin_in  <= i_beat.linear_speed;
            r_ang_in  <= i_beat.angular_speed;
            r_rd_prio <= mem_prio[i_beat.source_id[IW-1:0]];
            r_rd_hold <= mem_hold[i_beat.source_id[IW-1:0]];
        end
        if (i_cmd.execute && reg_ok) begin
            mem_prio[r_count[IW-1:0]] <= r_prio_in;
            mem_hold[r_count[IW-1:0]] <= r_hold_in;
        end
    end

    assign id_known  = CMPW'(r_id) < CMPW'(r_count);
    assign hold_arms = (r_rd_hold != 16'd0) && (r_rd_hold <= pvm_pkg::HOLD_MAX);
    assign tcnt_inc  = r_tcnt + 15'd1;

    always_comb begin
        n_count    = r_count;
        n_lock     = r_lock;
        n_tcnt     = r_tcnt;
        n_tlim     = r_tlim;
        n_trun     = r_trun;
        n_lin_hold = r_lin_hold;
        n_ang_hold = r_ang_hold;
        reg_ok     = 1'b0;
        accepted   = 1'b0;
        expired    = 1'b0;
        case (r_op)
            pvm_pkg::OP_REGISTER: begin
                if (r_count < CW'(MAX_SOURCES)) begin
                    reg_ok  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            pvm_pkg::OP_VELOCITY: begin
                if (id_known && (r_rd_prio <= r_lock)) begin
                    accepted   = 1'b1;
                    n_lin_hold = r_lin_in;
                    n_ang_hold = r_ang_in;
                    if (hold_arms) begin
                        n_lock = r_rd_prio;
                        // Hold is at most 2000, so the product fits 15 bits.
                        n_tlim = 15'(r_rd_hold) * pvm_pkg::TICKS_PER_HOLD;
                        n_tcnt = 15'd0;
                        n_trun = 1'b1;
                    end
                end
            end
            pvm_pkg::OP_TICK: begin
                if (r_trun) begin
                    n_tcnt = tcnt_inc;
                    if (tcnt_inc >= r_tlim) begin
                        n_lock  = pvm_pkg::LOCK_FREE;
                        n_trun  = 1'b0;
                        n_tcnt  = 15'd0;
                        expired = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        n_out.register_ok      = reg_ok;
        n_out.assigned_index   = reg_ok ? 4'(r_count) : 4'd0;
        n_out.command_accepted = accepted;
        n_out.held_linear      = n_lin_hold;
        n_out.held_angular     = n_ang_hold;
        n_out.lock_expired     = expired;
        n_out.lock_priority    = n_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_lock      <= pvm_pkg::LOCK_FREE;
            r_tcnt      <= '0;
            r_tlim      <= '0;
            r_trun      <= 1'b0;
            r_lin_hold  <= '0;
            r_ang_hold  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_count     <= n_count;
                r_lock      <= n_lock;
                r_tcnt      <= n_tcnt;
                r_tlim      <= n_tlim;
                r_trun      <= n_trun;
                r_lin_hold  <= n_lin_hold;
                r_ang_hold  <= n_ang_hold;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

endmodule

// File: dv/tb_priority_velocity_mux.sv
`timescale 1ns / 1ps
// Self-checking testbench for priority_velocity_mux: directed and random command beats,
// a built-in arbitration predictor and a per-field result scoreboard.
// Depends on pvm_pkg, pvm_if and the priority_velocity_mux RTL.
module tb_priority_velocity_mux;

    // The package has no name for operation code 3. The block must treat it as a no-op,
    // so the bench gives it a name of its own.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Must match the MAX_SOURCES value that the instance below is built with.
    localparam int TABLE_DEPTH = 16;

    // Stimulus plan. The random body follows the directed beats. The last stretch
    // runs without idling on either side.
    localparam int RANDOM_BEATS  = 1925;
    localparam int QUIET_AFTER   = 1650;
    localparam int DRAIN_AT_A    = 400;
    localparam int DRAIN_AT_B    = 1500;
    localparam int HOLDOFF_LEN   = 80;
    localparam int HOLDOFF_FIRST = 600;
    localparam int HOLDOFF_STEP  = 700;

    // A queued command beat. drain_first makes the driver hold back until every
    // outstanding result has come back before it offers this beat.
    typedef struct {
        pvm_pkg::t_in_beat beat;
        bit                drain_first;
    } t_cmd_item;

    logic i_clk;
    logic i_rst_n;

    pvm_in_if  cmd_ch ();
    pvm_out_if res_ch ();

    priority_velocity_mux #(
        .MAX_SOURCES(TABLE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch)
    );

    // Beats waiting to be offered, and the results that accepted beats must produce.
    t_cmd_item          queued_commands[$];
    pvm_pkg::t_out_beat awaited_outputs[$];

    // Predictor copy of the block state: the source table, the lock and its timer,
    // and the velocity pair that is currently driven.
    int          src_count;
    logic [7:0]  prio_tab [TABLE_DEPTH];
    logic [15:0] hold_tab [TABLE_DEPTH];
    logic [7:0]  lock_lvl;
    logic [14:0] tmo_cnt;
    logic [14:0] tmo_lim;
    bit          tmo_run;
    logic [31:0] lin_hold;
    logic [31:0] ang_hold;

    // Counters for the closing summary and for the verdict.
    int taken_count;
    int refused_count;
    int expiry_count;
    int full_refusals;
    int mismatch_count;
    int beats_sent;
    int results_seen;

    // Driver and monitor bookkeeping.
    int                 gap_left;
    int                 stall_left;
    int                 holdoff_left;
    int                 holdoffs_done;
    pvm_pkg::t_out_beat next_expected;

    // Clock, plus known levels on every block input from time zero.
    initial begin
        i_clk                 = 1'b0;
        i_rst_n               = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.operation      = '0;
        cmd_ch.source_id      = '0;
        cmd_ch.source_priority = '0;
        cmd_ch.hold_time      = '0;
        cmd_ch.linear_speed   = '0;
        cmd_ch.angular_speed  = '0;
        res_ch.ready          = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on the run time, so that a hung run still ends with a verdict.
    initial begin
        #5_000_000;
        $display("Timeout: %0d beats sent, %0d results seen, %0d still awaited",
                 beats_sent, results_seen, awaited_outputs.size());
        $display("priority_velocity_mux: mismatch");
        $finish;
    end

    // Predict the result of one accepted beat and update the predictor state.
    // Only table entries below src_count are ever read.
    function automatic pvm_pkg::t_out_beat arbitrate_beat(input pvm_pkg::t_in_beat b);
        pvm_pkg::t_out_beat r;
        r = '0;
        case (b.operation)
            pvm_pkg::OP_REGISTER: begin
                if (src_count < TABLE_DEPTH) begin
                    prio_tab[src_count] = b.source_priority;
                    hold_tab[src_count] = b.hold_time;
                    r.register_ok       = 1'b1;
                    r.assigned_index    = 4'(src_count);
                    src_count++;
                end else begin
                    full_refusals++;
                end
            end
            pvm_pkg::OP_VELOCITY: begin
                if (int'(b.source_id) < src_count &&
                        prio_tab[b.source_id] <= lock_lvl) begin
                    // A hold time outside 1..2000 still takes the command, but it does
                    // not touch the lock or the timer.
                    if (hold_tab[b.source_id] != 16'd0 &&
                            hold_tab[b.source_id] <= pvm_pkg::HOLD_MAX) begin
                        lock_lvl = prio_tab[b.source_id];
                        tmo_lim  = hold_tab[b.source_id][14:0] * pvm_pkg::TICKS_PER_HOLD;
                        tmo_cnt  = '0;
                        tmo_run  = 1'b1;
                    end
                    lin_hold           = b.linear_speed;
                    ang_hold           = b.angular_speed;
                    r.command_accepted = 1'b1;
                    taken_count++;
                end else begin
                    refused_count++;
                end
            end
            pvm_pkg::OP_TICK: begin
                // A tick with the timer stopped changes nothing.
                if (tmo_run) begin
                    tmo_cnt = tmo_cnt + 15'd1;
                    if (tmo_cnt >= tmo_lim) begin
                        lock_lvl        = pvm_pkg::LOCK_FREE;
                        tmo_run         = 1'b0;
                        tmo_cnt         = '0;
                        r.lock_expired  = 1'b1;
                        expiry_count++;
                    end
                end
            end
            default: ;
        endcase
        r.held_linear   = lin_hold;
        r.held_angular  = ang_hold;
        r.lock_priority = lock_lvl;
        return r;
    endfunction

    // Idling runs in phases: three busy windows with random gaps, then one clean window.
    // The tail of the run is left clean.
    function automatic bit idling_on(input int progress);
        return progress < QUIET_AFTER && ((progress / 150) % 4) != 3;
    endfunction

    // Every field gets a random value first. Callers then overwrite the fields that
    // matter for the operation.
    function automatic pvm_pkg::t_in_beat rand_beat(input logic [1:0] op);
        pvm_pkg::t_in_beat b;
        b.operation       = op;
        b.source_id       = 8'($urandom);
        b.source_priority = 8'($urandom);
        b.hold_time       = 16'($urandom);
        b.linear_speed    = $urandom;
        b.angular_speed   = $urandom;
        return b;
    endfunction

    task automatic queue_beat(input pvm_pkg::t_in_beat b, input bit drain_first);
        t_cmd_item c;
        c.beat        = b;
        c.drain_first = drain_first;
        queued_commands.push_back(c);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, name, got, want));
    endtask

    // Command driver. A beat that is offered is held until it is taken. The predictor
    // runs on the edge at which the beat is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (cmd_ch.valid && cmd_ch.ready) begin
                awaited_outputs.push_back(arbitrate_beat(queued_commands[0].beat));
                void'(queued_commands.pop_front());
                beats_sent++;
            end
            if (!(cmd_ch.valid && !cmd_ch.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_ch.valid <= 1'b0;
                end else if (queued_commands.size() == 0 ||
                             (queued_commands[0].drain_first &&
                              awaited_outputs.size() != 0)) begin
                    cmd_ch.valid <= 1'b0;
                end else if (idling_on(beats_sent) && $urandom_range(0, 7) == 0) begin
                    // A gap of random length, counting this one.
                    gap_left = $urandom_range(0, 4);
                    cmd_ch.valid <= 1'b0;
                end else begin
                    cmd_ch.valid           <= 1'b1;
                    cmd_ch.operation       <= queued_commands[0].beat.operation;
                    cmd_ch.source_id       <= queued_commands[0].beat.source_id;
                    cmd_ch.source_priority <= queued_commands[0].beat.source_priority;
                    cmd_ch.hold_time       <= queued_commands[0].beat.hold_time;
                    cmd_ch.linear_speed    <= queued_commands[0].beat.linear_speed;
                    cmd_ch.angular_speed   <= queued_commands[0].beat.angular_speed;
                end
            end
        end
    end

    // Result monitor and receiver. Each result beat is checked field by field against
    // the oldest prediction. Ready drops in short random bursts. Twice during the run
    // it also drops for a long stretch, so that the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left    = 0;
            holdoff_left  = 0;
            holdoffs_done = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (awaited_outputs.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing awaited",
                                              results_seen));
                end else begin
                    next_expected = awaited_outputs.pop_front();
                    check_field("register_ok", 32'(res_ch.register_ok),
                                32'(next_expected.register_ok));
                    check_field("assigned_index", 32'(res_ch.assigned_index),
                                32'(next_expected.assigned_index));
                    check_field("command_accepted", 32'(res_ch.command_accepted),
                                32'(next_expected.command_accepted));
                    check_field("held_linear", res_ch.held_linear,
                                next_expected.held_linear);
                    check_field("held_angular", res_ch.held_angular,
                                next_expected.held_angular);
                    check_field("lock_expired", 32'(res_ch.lock_expired),
                                32'(next_expected.lock_expired));
                    check_field("lock_priority", 32'(res_ch.lock_priority),
                                32'(next_expected.lock_priority));
                end
                results_seen++;
            end

            if (holdoff_left > 0) begin
                holdoff_left--;
                res_ch.ready <= 1'b0;
            end else if (holdoffs_done < 2 &&
                         results_seen >= HOLDOFF_FIRST + holdoffs_done * HOLDOFF_STEP) begin
                holdoff_left = HOLDOFF_LEN - 1;
                holdoffs_done++;
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else if (idling_on(results_seen) && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 4);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Stimulus plan, reset, and end of run.
    initial begin
        pvm_pkg::t_in_beat b;
        int                pick;

        src_count     = 0;
        lock_lvl      = pvm_pkg::LOCK_FREE;
        tmo_cnt       = '0;
        tmo_lim       = '0;
        tmo_run       = 1'b0;
        lin_hold      = '0;
        ang_hold      = '0;
        foreach (prio_tab[k]) begin
            prio_tab[k] = '0;
            hold_tab[k] = '0;
        end

        // Directed part. A command arrives while no source is registered, a tick
        // arrives while the timer is stopped, and the unused code comes through.
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd0; queue_beat(b, 1'b0);
        queue_beat(rand_beat(pvm_pkg::OP_TICK), 1'b0);
        queue_beat(rand_beat(OP_UNUSED), 1'b0);

        // Registrations cover the priority extremes and the hold times at and just past
        // the edges of the range that arms the lock.
        b = rand_beat(pvm_pkg::OP_REGISTER); b.source_priority = 8'd255; b.hold_time = 16'd0;
        queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_REGISTER); b.source_priority = 8'd0;   b.hold_time = 16'd1;
        queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_REGISTER); b.source_priority = 8'd100;
        b.hold_time = 16'd2000;
        queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_REGISTER); b.source_priority = 8'd50;
        b.hold_time = 16'd2001;
        queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_REGISTER); b.source_priority = 8'd200;
        b.hold_time = 16'hFFFF;
        queue_beat(b, 1'b0);

        // Source 0 wins against the free lock but does not arm it. Source 2 then takes
        // the lock at 100. After that, source 0 loses, and source 3 wins without moving
        // the lock. Source 1 takes the lock at 0 with a timeout of ten ticks.
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd0;
        b.linear_speed = 32'hFFFF_FFFF; b.angular_speed = 32'd0; queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd2;
        b.linear_speed = 32'd0; b.angular_speed = 32'hFFFF_FFFF; queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd0; queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd3; queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd1; queue_beat(b, 1'b0);
        // Commands from ids that are not registered, up to the top id.
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd5;   queue_beat(b, 1'b0);
        b = rand_beat(pvm_pkg::OP_VELOCITY); b.source_id = 8'd255; queue_beat(b, 1'b0);
        // Ten ticks. The last one ends the hold and frees the lock.
        repeat (10) queue_beat(rand_beat(pvm_pkg::OP_TICK), 1'b0);

        // Random body. Eleven registrations fill the table first, mostly with short
        // holds so that locks expire often. After that, a registration can only come
        // back refused because the table is full.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n < TABLE_DEPTH - 5) begin
                b = rand_beat(pvm_pkg::OP_REGISTER);
                b.source_priority = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                : 8'($urandom_range(20, 200));
                pick = $urandom_range(0, 99);
                if (pick < 60)      b.hold_time = 16'($urandom_range(1, 4));
                else if (pick < 75) b.hold_time = 16'($urandom_range(5, 40));
                else if (pick < 85) b.hold_time = 16'd0;
                else                b.hold_time = 16'($urandom_range(2001, 65535));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    b = rand_beat(pvm_pkg::OP_VELOCITY);
                    if ($urandom_range(0, 9) != 0)
                        b.source_id = 8'($urandom_range(0, TABLE_DEPTH - 1));
                end else if (pick < 90) begin
                    b = rand_beat(pvm_pkg::OP_TICK);
                end else if (pick < 95) begin
                    b = rand_beat(pvm_pkg::OP_REGISTER);
                end else begin
                    b = rand_beat(OP_UNUSED);
                end
            end
            queue_beat(b, n == DRAIN_AT_A || n == DRAIN_AT_B);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every beat has been taken and every result has come back. Then give
        // the block a few more cycles to show any stray result beat.
        while (queued_commands.size() != 0 || awaited_outputs.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Ran %0d command beats: %0d velocity commands taken, %0d refused,",
                 beats_sent, taken_count, refused_count);
        $display("%0d lock expiries; table filled to %0d entries, %0d registrations refused.",
                 expiry_count, src_count, full_refusals);
        if (mismatch_count == 0) begin
            $display("priority_velocity_mux: match");
        end else begin
            $display("priority_velocity_mux: mismatch");
        end
        $finish;
    end

endmodule
